@@ rtl/shct_pkg.sv @@
// ----------------------------------------------------------------------------
// shct_pkg
// shared types, constants and digit helpers for the settable 12-hour clock
// ----------------------------------------------------------------------------
package shct_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned HOUR_W  = 4;
    localparam int unsigned MS_W    = 6;
    localparam int unsigned REGION_W = 3;
    localparam int unsigned MASK_W  = 8;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = COORD_W'(320);
    localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(240);
    localparam logic [COORD_W-1:0] THIRD_RESET  = COORD_W'(320 / 3);

    localparam logic [HOUR_W-1:0] HOUR_MAX   = HOUR_W'(12);
    localparam logic [HOUR_W-1:0] HOUR_MIN   = HOUR_W'(1);
    localparam logic [MS_W-1:0]   MINSEC_MAX = MS_W'(59);

    localparam logic [MASK_W-1:0] MASK_ALL = 8'hFF;

    // register indexes on the config port
    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_idx_t;

    // touch region codes
    typedef enum logic [REGION_W-1:0] {
        REGION_NONE         = 3'd0,
        REGION_TOP_LEFT     = 3'd1,
        REGION_BOTTOM_LEFT  = 3'd2,
        REGION_TOP_MID      = 3'd3,
        REGION_BOTTOM_MID   = 3'd4,
        REGION_TOP_RIGHT    = 3'd5,
        REGION_BOTTOM_RIGHT = 3'd6
    } region_t;

    // width / 3 by reciprocal, exact for every 10-bit value
    function automatic logic [COORD_W-1:0] div3(input logic [COORD_W-1:0] w);
        logic [20:0] prod;
        prod = 21'(w) * 21'd683;
        return prod[20:11];
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [MS_W-1:0] v);
        logic [2:0] t;
        if (v >= MS_W'(60))      t = 3'd6;
        else if (v >= MS_W'(50)) t = 3'd5;
        else if (v >= MS_W'(40)) t = 3'd4;
        else if (v >= MS_W'(30)) t = 3'd3;
        else if (v >= MS_W'(20)) t = 3'd2;
        else if (v >= MS_W'(10)) t = 3'd1;
        else                     t = 3'd0;
        return t;
    endfunction

    // ones digit of a value below 64
    function automatic logic [3:0] ones_of(input logic [MS_W-1:0] v);
        logic [MS_W-1:0] rem;
        rem = v - MS_W'(tens_of(v)) * MS_W'(10);
        return rem[3:0];
    endfunction

    // two-bit change mask: bit 0 tens, bit 1 ones
    function automatic logic [1:0] pair_diff(input logic [MS_W-1:0] a,
                                             input logic [MS_W-1:0] b);
        logic [1:0] m;
        m[0] = (tens_of(a) != tens_of(b));
        m[1] = (ones_of(a) != ones_of(b));
        return m;
    endfunction

endpackage

@@ rtl/settable_hms_clock_touch.sv @@
// ----------------------------------------------------------------------------
// settable_hms_clock_touch
// 12-hour h:m:s clock advanced by ticks and set from a six-region touch panel
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------
//  s_       | in  | s_tvalid/s_tready | mode, touch_x, touch_y
//  m_       | out | m_tvalid/m_tready | hour, minute, second, region, mask
//  apb      | in  | psel/penable      | screen_width @0x0, screen_height @0x4
//
//  one item per cycle sustained while m_tready is high; each item passes
//  through the input register and then the result register
//  the clock state is read and written in the single compute step, so
//  back-to-back items see each other's updates
//  a stalled m_ side holds the result register and the input register
//  fills, after which s_tready drops
//  synchronous active-low reset restores 12:59:59 and the full-redraw flag
//
module settable_hms_clock_touch
    import shct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] mode, [10:1] touch_x, [20:11] touch_y, [23:21] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] hour_now, [9:4] minute_now, [15:10] second_now,
    // [18:16] touch_region, [26:19] changed_chars, [31:27] zero
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    // config registers; the third mark is worked out when the width is written
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;
    logic [COORD_W-1:0] third_reg;

    // input register
    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [COORD_W-1:0] in_x_reg;
    logic [COORD_W-1:0] in_y_reg;

    // clock and last shown time
    logic [HOUR_W-1:0]  hour_reg,  hour_next;
    logic [MS_W-1:0]    minute_reg, minute_next;
    logic [MS_W-1:0]    second_reg, second_next;
    logic [HOUR_W-1:0]  shown_hour_reg;
    logic [MS_W-1:0]    shown_minute_reg;
    logic [MS_W-1:0]    shown_second_reg;
    logic               shown_valid_reg;

    // result register
    logic               out_valid_reg;
    logic [HOUR_W-1:0]  out_hour_reg;
    logic [MS_W-1:0]    out_minute_reg;
    logic [MS_W-1:0]    out_second_reg;
    region_t            out_region_reg, region_next;
    logic [MASK_W-1:0]  out_mask_reg, mask_next;

    logic               advance;
    logic               fire;
    logic               refresh;
    logic               cfg_write;
    reg_idx_t           cfg_idx;
    logic [COORD_W-1:0] two_third;
    logic [COORD_W-1:0] mid;
    logic [1:0]         col;
    logic               col_ok;
    logic [1:0]         hour_diff, minute_diff, second_diff;

    // ---------------- config port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_comb begin
        case (cfg_idx)
            REG_SCREEN_WIDTH:  prdata = APB_DW'(width_reg);
            REG_SCREEN_HEIGHT: prdata = APB_DW'(height_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            third_reg  <= THIRD_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SCREEN_WIDTH: begin
                    width_reg <= pwdata[COORD_W-1:0];
                    third_reg <= div3(pwdata[COORD_W-1:0]);
                end
                REG_SCREEN_HEIGHT: height_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    // result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tdata[0];
            in_x_reg    <= s_tdata[10:1];
            in_y_reg    <= s_tdata[20:11];
        end
    end

    // ---------------- region lookup ----------------
    // a touch exactly on a third mark or on the half mark hits no region
    assign two_third = {third_reg[COORD_W-2:0], 1'b0};
    assign mid       = {1'b0, height_reg[COORD_W-1:1]};

    always_comb begin
        col    = 2'd0;
        col_ok = 1'b1;
        if (in_x_reg < third_reg)                              col = 2'd0;
        else if (in_x_reg > third_reg && in_x_reg < two_third) col = 2'd1;
        else if (in_x_reg > two_third)                         col = 2'd2;
        else                                                   col_ok = 1'b0;

        region_next = REGION_NONE;
        if (in_mode_reg && col_ok) begin
            if (in_y_reg < mid)
                region_next = region_t'({col, 1'b0} + 3'd1);
            else if (in_y_reg > mid)
                region_next = region_t'({col, 1'b0} + 3'd2);
        end
    end

    // ---------------- time update ----------------
    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;

        // a tick behaves as a top-right touch
        case (in_mode_reg ? region_next : REGION_TOP_RIGHT)
            REGION_TOP_LEFT:
                hour_next = (hour_reg < HOUR_MAX) ? hour_reg + HOUR_W'(1) : HOUR_MIN;
            REGION_BOTTOM_LEFT:
                hour_next = (hour_reg > HOUR_MIN) ? hour_reg - HOUR_W'(1) : HOUR_MAX;
            REGION_TOP_MID: begin
                if (minute_reg < MINSEC_MAX) begin
                    minute_next = minute_reg + MS_W'(1);
                end else begin
                    minute_next = '0;
                    hour_next = (hour_reg < HOUR_MAX) ? hour_reg + HOUR_W'(1) : HOUR_MIN;
                end
            end
            REGION_BOTTOM_MID:
                minute_next = (minute_reg > '0) ? minute_reg - MS_W'(1) : MINSEC_MAX;
            REGION_TOP_RIGHT: begin
                if (second_reg < MINSEC_MAX) begin
                    second_next = second_reg + MS_W'(1);
                end else begin
                    second_next = '0;
                    if (minute_reg < MINSEC_MAX) begin
                        minute_next = minute_reg + MS_W'(1);
                    end else begin
                        minute_next = '0;
                        hour_next = (hour_reg < HOUR_MAX) ? hour_reg + HOUR_W'(1)
                                                          : HOUR_MIN;
                    end
                end
            end
            REGION_BOTTOM_RIGHT:
                second_next = (second_reg > '0) ? second_reg - MS_W'(1) : MINSEC_MAX;
            default: ;
        endcase
    end

    // ---------------- change mask ----------------
    assign refresh     = !in_mode_reg || (region_next != REGION_NONE);
    assign hour_diff   = pair_diff(MS_W'(shown_hour_reg), MS_W'(hour_next));
    assign minute_diff = pair_diff(shown_minute_reg, minute_next);
    assign second_diff = pair_diff(shown_second_reg, second_next);

    always_comb begin
        if (!refresh)
            mask_next = '0;
        else if (!shown_valid_reg)
            mask_next = MASK_ALL;          // first update redraws everything
        else
            mask_next = {second_diff, 1'b0, minute_diff, 1'b0, hour_diff};
    end

    // ---------------- state and result registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg         <= HOUR_MAX;
            minute_reg       <= MINSEC_MAX;
            second_reg       <= MINSEC_MAX;
            shown_hour_reg   <= '0;
            shown_minute_reg <= '0;
            shown_second_reg <= '0;
            shown_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (fire) begin
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                if (refresh) begin
                    shown_hour_reg   <= hour_next;
                    shown_minute_reg <= minute_next;
                    shown_second_reg <= second_next;
                    shown_valid_reg  <= 1'b1;
                end
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_hour_reg   <= hour_next;
            out_minute_reg <= minute_next;
            out_second_reg <= second_next;
            out_region_reg <= region_next;
            out_mask_reg   <= mask_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_mask_reg, out_region_reg, out_second_reg,
                       out_minute_reg, out_hour_reg};

endmodule

@@ rtl/shct_checker.sv @@
// ----------------------------------------------------------------------------
// shct_checker
// port-level checks for the settable 12-hour clock, bound to the top level
// ----------------------------------------------------------------------------
module shct_checker
    import shct_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // held result does not change while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // shown time stays on a 12-hour dial
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] >= HOUR_MIN && m_tdata[3:0] <= HOUR_MAX
                     && m_tdata[9:4] <= MINSEC_MAX && m_tdata[15:10] <= MINSEC_MAX)
        else $error("time out of range");

    // colons only change together, on a full redraw
    a_colon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[21] == m_tdata[24])
        else $error("colon marks disagree");

    // a real region always moves some digit
    a_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18:16] != REGION_NONE |-> m_tdata[26:19] != '0)
        else $error("touch region with empty change mask");

endmodule

bind settable_hms_clock_touch shct_checker u_shct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
